// ===== src/unsorted_max_priority_queue_assert.svh =====
// Assertion macros for the unsorted max-priority queue RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef UNSORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define UMPQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define UMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/umpq_pkg.sv =====
// Package for the unsorted max-priority queue: operation codes and sequencer states.
// Has no dependencies; the RTL files refer to it by scoped names.
package umpq_pkg;

  // Operation codes carried in the op field of an input transfer.
  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpClear  = 2'd2
  } op_e;

  // One-hot states of the remove sequencer.
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StShift = 4'b0100,
    StDone  = 4'b1000
  } state_e;

endpackage

// ===== src/unsorted_max_priority_queue.sv =====
// Max-priority queue held unsorted in insertion order in one RAM, with a
// single comparator that scans the entries for the largest key. Depends on
// umpq_pkg, umpq_ram and unsorted_max_priority_queue_assert.svh.
//
// Each input transfer carries one operation and produces exactly one output
// transfer. For insert, clear-counter and the unused code the result is in
// the output register on the cycle after the input transfer. A remove from
// a queue of one entry or more first issues the read of entry 0, then has
// the comparator look at the entries one by one, then moves the entries
// after the one taken down by one slot (one RAM read and one RAM write per
// cycle, plus a last step to finish the final write; nothing is moved when
// the entry taken is the last one), and then presents the result. The
// single RAM read port and the single comparator make the scan look at one
// entry at a time. A remove from an empty queue is answered on the cycle
// after the input transfer with removed_valid low.
// The block takes no new input transfer while a remove is in progress, nor
// while the output register holds a result that is stalled. An insert into
// a full queue is answered with insert_rejected high and changes nothing.
// Ties between equal keys go to the oldest entry. The comparison counter
// adds one for each entry after the first that a remove looks at, and one
// more each time a strictly larger key becomes the new maximum; it
// saturates at all ones and is cleared by the clear operation. Stored keys
// are KEY_BITS wide, taken from key_in with sign extension or truncation.
// Occupancy reports the entry count modulo 32.
module unsorted_max_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] key_in_i,
  input  logic [31:0]        payload_in_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               removed_valid_o,
  output logic signed [31:0] key_out_o,
  output logic [31:0]        payload_out_o,
  output logic               insert_rejected_o,
  output logic [4:0]         occupancy_o,
  output logic [31:0]        comparisons_o
);

  `include "unsorted_max_priority_queue_assert.svh"

  // Index width for the RAM and count width that can hold the depth itself.
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  // Each RAM word holds the key in its upper bits and the payload below.
  localparam int unsigned EW = KEY_BITS + 32;

  // Adds a small increment to the comparison counter, holding at all ones.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {31'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  umpq_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   cmp_q, cmp_d;
  // Read pointer, shared by the scan and the shift phases.
  logic [CW-1:0] ptr_q, ptr_d;
  // Write pointer of the shift phase.
  logic [IW-1:0] dst_q, dst_d;
  logic          first_q, first_d;
  logic          pend_q, pend_d;

  logic [IW-1:0]              best_idx_q, best_idx_d;
  logic signed [KEY_BITS-1:0] best_key_q, best_key_d;
  logic [31:0]                best_pay_q, best_pay_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic               rv_q;
  logic signed [31:0] key_out_q;
  logic [31:0]        pay_out_q;
  logic               rej_q;
  logic [4:0]         occ_q;
  logic [31:0]        cmp_out_q;

  logic               out_load;
  logic               ld_rv;
  logic signed [31:0] ld_key;
  logic [31:0]        ld_pay;
  logic               ld_rej;

  // RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic                       in_acc;
  logic                       out_free;
  logic signed [63:0]         key_in_sx;
  logic signed [63:0]         best_sx;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [31:0]                rd_pay;
  logic                       rd_greater;
  logic [CW-1:0]              scan_idx;
  logic                       rd_more;

  // The output register is free when it is empty or is drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != umpq_pkg::StIdle) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Keys are sign-extended to 64 bits, then cut to the stored width.
  assign key_in_sx  = 64'(key_in_i);
  assign best_sx    = 64'(best_key_q);

  assign rd_key     = ram_rdata[EW-1:32];
  assign rd_pay     = ram_rdata[31:0];
  assign rd_greater = rd_key > best_key_q;
  // Index of the entry whose data sits on the RAM read port during a scan.
  assign scan_idx   = ptr_q - CW'(1);
  assign rd_more    = ptr_q < count_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cmp_d      = cmp_q;
    ptr_d      = ptr_q;
    dst_d      = dst_q;
    first_d    = first_q;
    pend_d     = pend_q;
    best_idx_d = best_idx_q;
    best_key_d = best_key_q;
    best_pay_d = best_pay_q;

    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[IW-1:0];

    out_load = 1'b0;
    ld_rv    = 1'b0;
    ld_key   = '0;
    ld_pay   = '0;
    ld_rej   = 1'b0;

    unique case (state_q)
      umpq_pkg::StIdle: begin
        if (in_acc) begin
          unique case (umpq_pkg::op_e'(op_i))
            umpq_pkg::OpInsert: begin
              out_load = 1'b1;
              if (count_q >= CW'(QUEUE_DEPTH)) begin
                ld_rej = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IW-1:0];
                ram_wdata = {key_in_sx[KEY_BITS-1:0], payload_in_i};
                count_d   = count_q + CW'(1);
              end
            end
            umpq_pkg::OpRemove: begin
              if (count_q == '0) begin
                out_load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = CW'(1);
                first_d   = 1'b1;
                state_d   = umpq_pkg::StScan;
              end
            end
            umpq_pkg::OpClear: begin
              cmp_d    = '0;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      umpq_pkg::StScan: begin
        if (first_q) begin
          best_key_d = rd_key;
          best_pay_d = rd_pay;
          best_idx_d = '0;
          first_d    = 1'b0;
        end else begin
          cmp_d = sat_add(cmp_q, rd_greater ? 2'd2 : 2'd1);
          if (rd_greater) begin
            best_key_d = rd_key;
            best_pay_d = rd_pay;
            best_idx_d = scan_idx[IW-1:0];
          end
        end
        if (rd_more) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CW'(1);
        end else begin
          // Every entry has been seen: close the gap behind the maximum.
          state_d = umpq_pkg::StShift;
          ptr_d   = CW'(best_idx_d) + CW'(1);
          dst_d   = best_idx_d;
          pend_d  = 1'b0;
        end
      end

      umpq_pkg::StShift: begin
        pend_d = rd_more;
        if (rd_more) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CW'(1);
        end
        if (pend_q) begin
          ram_we = 1'b1;
          dst_d  = dst_q + IW'(1);
        end
        if (!rd_more && !pend_q) begin
          state_d = umpq_pkg::StDone;
        end
      end

      umpq_pkg::StDone: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_rv    = 1'b1;
          ld_key   = best_sx[31:0];
          ld_pay   = best_pay_q;
          count_d  = count_q - CW'(1);
          state_d  = umpq_pkg::StIdle;
        end
      end

      default: begin
        state_d = umpq_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= umpq_pkg::StIdle;
      count_q     <= '0;
      cmp_q       <= '0;
      ptr_q       <= '0;
      dst_q       <= '0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_q       <= cmp_d;
      ptr_q       <= ptr_d;
      dst_q       <= dst_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Running maximum and output payload registers need no reset.
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_key_q <= best_key_d;
    best_pay_q <= best_pay_d;
    if (out_load) begin
      rv_q      <= ld_rv;
      key_out_q <= ld_key;
      pay_out_q <= ld_pay;
      rej_q     <= ld_rej;
      occ_q     <= 5'(count_d);
      cmp_out_q <= cmp_d;
    end
  end

  umpq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign removed_valid_o   = rv_q;
  assign key_out_o         = key_out_q;
  assign payload_out_o     = pay_out_q;
  assign insert_rejected_o = rej_q;
  assign occupancy_o       = occ_q;
  assign comparisons_o     = cmp_out_q;

  `UMPQ_ASSERT(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH), "entry count above depth")
  `UMPQ_ASSERT(a_shift_order, ram_we && (state_q == umpq_pkg::StShift), CW'(dst_q) < ptr_q, "shift write not below read")
  `UMPQ_ASSERT(a_best_range, (state_q == umpq_pkg::StScan) && !first_q, CW'(best_idx_q) < count_q, "best index out of range")
  `UMPQ_ASSERT_NEXT(a_remove_count, (state_q == umpq_pkg::StDone) && out_free, count_q == ($past(count_q) - CW'(1)), "remove did not drop count")
  `UMPQ_ASSERT_NEXT(a_cmp_monotonic, !(in_acc && (op_i == umpq_pkg::OpClear)), cmp_q >= $past(cmp_q), "counter fell without clear")

endmodule

// ===== src/umpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies; used for the entry store of the priority queue.
module umpq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
